// ----- design/bcb_pkg.sv -----
package bcb_pkg;

    localparam int CAPACITY_DEF     = 4096;
    localparam int MAX_TRANSFER_DEF = 64;
    localparam int OP_W             = 3;
    localparam int LEN_W            = 13;
    localparam int BYTE_W           = 8;
    localparam int STATUS_W         = 2;
    localparam int CMDQ_DEPTH       = 2;
    localparam int RESQ_DEPTH       = 4;

    typedef enum logic [OP_W-1:0] {
        OP_ENQ_START  = 3'd0,
        OP_ENQ_DATA   = 3'd1,
        OP_DEQUEUE    = 3'd2,
        OP_PEEK       = 3'd3,
        OP_ADV_READ   = 3'd4,
        OP_ADV_WRITE  = 3'd5,
        OP_CLEAR      = 3'd6,
        OP_INVALID    = 3'd7
    } opcode_t;

    typedef logic [STATUS_W-1:0] status_t;

    localparam status_t ST_ACCEPT = 2'd0;
    localparam status_t ST_REFUSE = 2'd1;
    localparam status_t ST_DATA   = 2'd2;

    typedef struct packed {
        opcode_t            op;
        logic [LEN_W-1:0]   len;
        logic [BYTE_W-1:0]  din;
        logic               too_long;
        logic               len_zero;
    } cmd_t;

    typedef struct packed {
        status_t            status;
        logic [BYTE_W-1:0]  data;
        logic               last;
        logic [LEN_W-1:0]   used;
        logic [LEN_W-1:0]   free;
        logic [LEN_W-1:0]   wspan;
        logic [LEN_W-1:0]   rspan;
    } result_t;

    typedef enum logic {
        BK_IDLE,
        BK_BURST
    } back_state_t;

endpackage

// ----- design/bcb_queue.sv -----
module bcb_queue #(
    parameter type T     = logic,
    parameter int  DEPTH = 2
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  T                           din,
    output logic                       full,
    input  logic                       pop,
    output T                           dout,
    output logic                       empty,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    T                slot_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg;
    logic [PW-1:0]   rd_ptr_next;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;
    logic            do_push;
    logic            do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign count   = count_reg;
    assign dout    = slot_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

// ----- design/bcb_front.sv -----
module bcb_front #(
    parameter int MAX_TRANSFER = bcb_pkg::MAX_TRANSFER_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic [bcb_pkg::OP_W-1:0]    opcode,
    input  logic [bcb_pkg::LEN_W-1:0]   transfer_length,
    input  logic [bcb_pkg::BYTE_W-1:0]  data_byte_in,
    output logic                        cmd_push,
    output bcb_pkg::cmd_t               cmd,
    input  logic                        cmd_full
);

    import bcb_pkg::*;

    logic   valid_reg;
    logic   valid_next;
    cmd_t   cmd_reg;
    cmd_t   cmd_next;
    logic   accept;

    assign full     = valid_reg && cmd_full;
    assign accept   = push && !full;
    assign cmd_push = valid_reg;
    assign cmd      = cmd_reg;

    // Decode the beat; the length limit of dequeue and peek is settled here.
    always_comb
    begin
        cmd_next.op       = opcode_t'(opcode);
        cmd_next.len      = transfer_length;
        cmd_next.din      = data_byte_in;
        cmd_next.too_long = (transfer_length > LEN_W'(MAX_TRANSFER));
        cmd_next.len_zero = (transfer_length == '0);
        valid_next        = accept || (valid_reg && cmd_full);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd_next;
        end
    end

endmodule

// ----- design/bcb_back.sv -----
module bcb_back #(
    parameter int CAPACITY     = bcb_pkg::CAPACITY_DEF,
    parameter int MAX_TRANSFER = bcb_pkg::MAX_TRANSFER_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cmd_empty,
    input  bcb_pkg::cmd_t                           cmd,
    output logic                                    cmd_pop,
    input  logic [$clog2(bcb_pkg::RESQ_DEPTH+1)-1:0] res_count,
    output logic                                    res_push,
    output bcb_pkg::result_t                        res
);

    import bcb_pkg::*;

    localparam int IW  = $clog2(CAPACITY);
    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int AW  = (CW > LEN_W) ? CW : LEN_W;
    localparam int BW  = $clog2(MAX_TRANSFER + 1);
    localparam int RCW = $clog2(RESQ_DEPTH + 1);
    localparam logic [AW:0]   CAP_A = (AW + 1)'(CAPACITY);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    function automatic logic [IW-1:0] wrap_add(input logic [IW-1:0] idx,
                                               input logic [AW-1:0] n);
        logic [AW:0] s;
        s = (AW + 1)'(idx) + (AW + 1)'(n);
        if (s >= CAP_A)
        begin
            s = s - CAP_A;
        end
        return s[IW-1:0];
    endfunction

    function automatic logic [LEN_W-1:0] fit_len(input logic [CW-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        return w[LEN_W-1:0];
    endfunction

    logic [BYTE_W-1:0] byte_store [CAPACITY];
    logic [BYTE_W-1:0] rdata_reg;

    back_state_t       state_reg,       state_next;
    logic [IW-1:0]     rd_idx_reg,      rd_idx_next;
    logic [IW-1:0]     wr_idx_reg,      wr_idx_next;
    logic [CW-1:0]     fill_reg,        fill_next;
    logic [LEN_W-1:0]  pend_reg,        pend_next;
    logic              pend_ref_reg,    pend_ref_next;
    logic [IW-1:0]     burst_addr_reg,  burst_addr_next;
    logic [BW-1:0]     burst_left_reg,  burst_left_next;
    logic              s1_valid_reg,    s1_valid_next;
    status_t           s1_status_reg,   s1_status_next;
    logic              s1_last_reg,     s1_last_next;
    logic              s1_mem_reg,      s1_mem_next;

    logic              issue_ok;
    logic              burst_end;
    logic [AW-1:0]     len_a;
    logic [AW-1:0]     fill_a;
    logic [AW-1:0]     free_a;
    logic [CW-1:0]     free_c;
    logic [CW-1:0]     wr_room;
    logic [CW-1:0]     rd_room;
    logic              mem_we;
    logic              mem_re;
    logic [IW-1:0]     mem_addr;

    assign free_c    = CAP_C - fill_reg;
    assign len_a     = AW'(cmd.len);
    assign fill_a    = AW'(fill_reg);
    assign free_a    = AW'(free_c);
    assign issue_ok  = (res_count <= RCW'(RESQ_DEPTH - 2));
    assign burst_end = (burst_left_reg == BW'(1));

    always_comb
    begin
        state_next      = state_reg;
        rd_idx_next     = rd_idx_reg;
        wr_idx_next     = wr_idx_reg;
        fill_next       = fill_reg;
        pend_next       = pend_reg;
        pend_ref_next   = pend_ref_reg;
        burst_addr_next = burst_addr_reg;
        burst_left_next = burst_left_reg;
        s1_valid_next   = 1'b0;
        s1_status_next  = ST_ACCEPT;
        s1_last_next    = 1'b1;
        s1_mem_next     = 1'b0;
        cmd_pop         = 1'b0;
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        mem_addr        = wr_idx_reg;

        unique case (state_reg)
            BK_IDLE:
            begin
                if (!cmd_empty && issue_ok)
                begin
                    cmd_pop       = 1'b1;
                    s1_valid_next = 1'b1;
                    unique case (cmd.op)
                        OP_ENQ_START:
                        begin
                            pend_next = cmd.len;
                            if (len_a > free_a)
                            begin
                                pend_ref_next  = 1'b1;
                                s1_status_next = ST_REFUSE;
                            end
                            else
                            begin
                                pend_ref_next = 1'b0;
                            end
                        end
                        OP_ENQ_DATA:
                        begin
                            if (pend_reg == '0)
                            begin
                                s1_status_next = ST_REFUSE;
                            end
                            else
                            begin
                                // Count the byte even when it cannot be stored.
                                pend_next = pend_reg - 1'b1;
                                if (pend_ref_reg || fill_reg == CAP_C)
                                begin
                                    s1_status_next = ST_REFUSE;
                                end
                                else
                                begin
                                    mem_we      = 1'b1;
                                    wr_idx_next = wrap_add(wr_idx_reg, AW'(1));
                                    fill_next   = fill_reg + 1'b1;
                                end
                            end
                        end
                        OP_DEQUEUE, OP_PEEK:
                        begin
                            if (cmd.too_long || fill_reg == '0 || len_a > fill_a)
                            begin
                                s1_status_next = ST_REFUSE;
                            end
                            else if (!cmd.len_zero)
                            begin
                                // Commit the new occupancy now; bytes follow.
                                s1_valid_next   = 1'b0;
                                state_next      = BK_BURST;
                                burst_addr_next = rd_idx_reg;
                                burst_left_next = BW'(cmd.len);
                                if (cmd.op == OP_DEQUEUE)
                                begin
                                    rd_idx_next = wrap_add(rd_idx_reg, len_a);
                                    fill_next   = fill_reg - CW'(cmd.len);
                                end
                            end
                        end
                        OP_ADV_READ:
                        begin
                            if (len_a > fill_a)
                            begin
                                s1_status_next = ST_REFUSE;
                            end
                            else
                            begin
                                rd_idx_next = wrap_add(rd_idx_reg, len_a);
                                fill_next   = fill_reg - CW'(cmd.len);
                            end
                        end
                        OP_ADV_WRITE:
                        begin
                            if (len_a > free_a)
                            begin
                                s1_status_next = ST_REFUSE;
                            end
                            else
                            begin
                                wr_idx_next = wrap_add(wr_idx_reg, len_a);
                                fill_next   = fill_reg + CW'(cmd.len);
                            end
                        end
                        OP_CLEAR:
                        begin
                            rd_idx_next   = '0;
                            wr_idx_next   = '0;
                            fill_next     = '0;
                            pend_next     = '0;
                            pend_ref_next = 1'b0;
                        end
                        OP_INVALID:
                        begin
                            s1_status_next = ST_REFUSE;
                        end
                    endcase
                end
            end
            BK_BURST:
            begin
                if (issue_ok)
                begin
                    mem_re          = 1'b1;
                    mem_addr        = burst_addr_reg;
                    s1_valid_next   = 1'b1;
                    s1_status_next  = ST_DATA;
                    s1_mem_next     = 1'b1;
                    s1_last_next    = burst_end;
                    burst_addr_next = wrap_add(burst_addr_reg, AW'(1));
                    burst_left_next = burst_left_reg - 1'b1;
                    if (burst_end)
                    begin
                        state_next = BK_IDLE;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= BK_IDLE;
            rd_idx_reg     <= '0;
            wr_idx_reg     <= '0;
            fill_reg       <= '0;
            pend_reg       <= '0;
            pend_ref_reg   <= 1'b0;
            burst_left_reg <= '0;
            s1_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            rd_idx_reg     <= rd_idx_next;
            wr_idx_reg     <= wr_idx_next;
            fill_reg       <= fill_next;
            pend_reg       <= pend_next;
            pend_ref_reg   <= pend_ref_next;
            burst_left_reg <= burst_left_next;
            s1_valid_reg   <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        burst_addr_reg <= burst_addr_next;
        s1_status_reg  <= s1_status_next;
        s1_last_reg    <= s1_last_next;
        s1_mem_reg     <= s1_mem_next;
    end

    // Single-port byte store: one write or one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            byte_store[mem_addr] <= cmd.din;
        end
        else if (mem_re)
        begin
            rdata_reg <= byte_store[mem_addr];
        end
    end

    // The state registers already hold the post-step occupancy of the item in s1.
    assign wr_room = CAP_C - CW'(wr_idx_reg);
    assign rd_room = CAP_C - CW'(rd_idx_reg);

    always_comb
    begin
        res_push   = s1_valid_reg;
        res.status = s1_status_reg;
        res.data   = s1_mem_reg ? rdata_reg : '0;
        res.last   = s1_last_reg;
        res.used   = fit_len(fill_reg);
        res.free   = fit_len(free_c);
        res.wspan  = fit_len((free_c < wr_room) ? free_c : wr_room);
        res.rspan  = fit_len((fill_reg < rd_room) ? fill_reg : rd_room);
    end

endmodule

// ----- design/circular_byte_buffer.sv -----
// Byte ring buffer with a queue-like port on each side. Push a beat when full
// is low; it carries an opcode (enqueue start, enqueue data, dequeue, peek,
// advance read, advance write, clear), a length and a data byte. Results come
// out oldest first while empty is low and leave on pop. Every item gives one
// result, except a successful dequeue or peek of N bytes (N from 1 to
// MAX_TRANSFER), which gives N data results with last set on the final one.
// Each result reports used and free bytes and the contiguous write and read
// spans after the whole item. Single-result items flow at one per cycle while
// pop keeps up; a dequeue or peek of N bytes holds the back end for its burst,
// reading one byte per cycle, while pop keeps up, out of the single-port byte
// memory. The first result of a beat passes through the front register, the
// command queue, the execute/memory register and the result queue before it
// shows on the result ports. The byte store powers up with undefined contents
// and needs no clearing pass; bytes reachable only through advance write read
// back as garbage.
module circular_byte_buffer #(
    parameter int CAPACITY     = bcb_pkg::CAPACITY_DEF,
    parameter int MAX_TRANSFER = bcb_pkg::MAX_TRANSFER_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [bcb_pkg::OP_W-1:0]      opcode,
    input  logic [bcb_pkg::LEN_W-1:0]     transfer_length,
    input  logic [bcb_pkg::BYTE_W-1:0]    data_byte_in,
    output logic                          empty,
    input  logic                          pop,
    output logic [bcb_pkg::STATUS_W-1:0]  status,
    output logic [bcb_pkg::BYTE_W-1:0]    data_byte_out,
    output logic                          last,
    output logic [bcb_pkg::LEN_W-1:0]     bytes_used,
    output logic [bcb_pkg::LEN_W-1:0]     bytes_free,
    output logic [bcb_pkg::LEN_W-1:0]     write_span,
    output logic [bcb_pkg::LEN_W-1:0]     read_span
);

    import bcb_pkg::*;

    localparam int RCW = $clog2(RESQ_DEPTH + 1);

    // Front to command queue.
    logic               cq_push;
    cmd_t               cq_din;
    logic               cq_full;
    // Command queue to back end.
    cmd_t               cq_dout;
    logic               cq_empty;
    logic               cq_pop;
    // Back end to result queue.
    logic               rq_push;
    result_t            rq_din;
    result_t            rq_dout;
    logic [RCW-1:0]     rq_count;

    // Decode and hold one beat; stall push only when the command queue backs up.
    bcb_front #(
        .MAX_TRANSFER (MAX_TRANSFER)
    ) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .opcode          (opcode),
        .transfer_length (transfer_length),
        .data_byte_in    (data_byte_in),
        .cmd_push        (cq_push),
        .cmd             (cq_din),
        .cmd_full        (cq_full)
    );

    // Decouple decode from execution so a long burst does not stall input at once.
    bcb_queue #(
        .T     (cmd_t),
        .DEPTH (CMDQ_DEPTH)
    ) u_cmd_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cq_push),
        .din   (cq_din),
        .full  (cq_full),
        .pop   (cq_pop),
        .dout  (cq_dout),
        .empty (cq_empty),
        .count ()
    );

    // Execute against the indices, fill count and byte store.
    bcb_back #(
        .CAPACITY     (CAPACITY),
        .MAX_TRANSFER (MAX_TRANSFER)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_empty (cq_empty),
        .cmd       (cq_dout),
        .cmd_pop   (cq_pop),
        .res_count (rq_count),
        .res_push  (rq_push),
        .res       (rq_din)
    );

    // Hold finished results; the back end only issues when a slot is guaranteed.
    bcb_queue #(
        .T     (result_t),
        .DEPTH (RESQ_DEPTH)
    ) u_res_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (rq_push),
        .din   (rq_din),
        .full  (),
        .pop   (pop),
        .dout  (rq_dout),
        .empty (empty),
        .count (rq_count)
    );

    assign status        = rq_dout.status;
    assign data_byte_out = rq_dout.data;
    assign last          = rq_dout.last;
    assign bytes_used    = rq_dout.used;
    assign bytes_free    = rq_dout.free;
    assign write_span    = rq_dout.wspan;
    assign read_span     = rq_dout.rspan;

endmodule

// ----- design/bcb_checker.sv -----
module bcb_checker #(
    parameter int CAPACITY = bcb_pkg::CAPACITY_DEF
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          empty,
    input logic                          pop,
    input logic [bcb_pkg::STATUS_W-1:0]  status,
    input logic [bcb_pkg::BYTE_W-1:0]    data_byte_out,
    input logic                          last,
    input logic [bcb_pkg::LEN_W-1:0]     bytes_used,
    input logic [bcb_pkg::LEN_W-1:0]     bytes_free,
    input logic [bcb_pkg::LEN_W-1:0]     write_span,
    input logic [bcb_pkg::LEN_W-1:0]     read_span
);

    import bcb_pkg::*;

    // Used and free always add up to the capacity.
    a_occupancy_sum: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (LEN_W'(bytes_used + bytes_free) == LEN_W'(CAPACITY)))
        else $error("used plus free differs from capacity");

    // Spans never exceed the totals they are cut from.
    a_span_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && CAPACITY < 8192) |->
            (write_span <= bytes_free && read_span <= bytes_used))
        else $error("span exceeds free or used count");

    // Status and control results carry no byte and close their item.
    a_non_data_result: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && status != ST_DATA) |-> (data_byte_out == '0 && last))
        else $error("non-data result with byte or without last");

    // Hold a waiting result until it is popped.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=>
            (!empty && $stable(status) && $stable(data_byte_out) && $stable(last)
             && $stable(bytes_used) && $stable(read_span)))
        else $error("waiting result changed before pop");

endmodule

bind circular_byte_buffer bcb_checker #(.CAPACITY(CAPACITY)) u_bcb_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .empty         (empty),
    .pop           (pop),
    .status        (status),
    .data_byte_out (data_byte_out),
    .last          (last),
    .bytes_used    (bytes_used),
    .bytes_free    (bytes_free),
    .write_span    (write_span),
    .read_span     (read_span)
);

// ----- test/testbench.sv -----
module testbench;

    import bcb_pkg::*;

    localparam int RING_BYTES      = CAPACITY_DEF;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int HOLD_OFF_ITEMS  = 12;
    localparam int PHASE_ITEMS     = 13;

    // Ring indices are exactly as wide as the capacity (a power of two), so
    // plain addition on them wraps the same way the block does.
    typedef logic [$clog2(RING_BYTES)-1:0] ring_ptr_t;

    // Shadow copy of the ring: applies every accepted beat to its own state
    // and keeps the result beats that the block still owes, oldest first.
    class byte_ring_shadow;
        logic [BYTE_W-1:0] store [RING_BYTES];
        bit                written [RING_BYTES];
        ring_ptr_t         rd_ptr;
        ring_ptr_t         wr_ptr;
        logic [LEN_W-1:0]  fill;
        logic [LEN_W-1:0]  pend;
        bit                pend_refused;
        result_t           awaited_results [$];
        int unsigned       mismatches;
        int unsigned       beats_checked;

        function new();
            rd_ptr = '0;
            wr_ptr = '0;
            fill = '0;
            pend = '0;
            pend_refused = 1'b0;
            mismatches = 0;
            beats_checked = 0;
            foreach (written[i])
                written[i] = 1'b0;
        endfunction

        // True when the next count bytes at the read index were ever stored.
        function bit bytes_defined(int unsigned count);
            ring_ptr_t p;
            p = rd_ptr;
            for (int unsigned i = 0; i < count; i++)
            begin
                if (!written[p])
                    return 1'b0;
                p++;
            end
            return 1'b1;
        endfunction

        // Occupancy fields always reflect the state after the whole item.
        function result_t snapshot(status_t st, logic [BYTE_W-1:0] b, logic lst);
            result_t          r;
            logic [LEN_W-1:0] room;
            logic [LEN_W-1:0] w_to_end;
            logic [LEN_W-1:0] r_to_end;
            room = LEN_W'(RING_BYTES) - fill;
            w_to_end = LEN_W'(RING_BYTES) - {1'b0, wr_ptr};
            r_to_end = LEN_W'(RING_BYTES) - {1'b0, rd_ptr};
            r.status = st;
            r.data = b;
            r.last = lst;
            r.used = fill;
            r.free = room;
            r.wspan = (room < w_to_end) ? room : w_to_end;
            r.rspan = (fill < r_to_end) ? fill : r_to_end;
            return r;
        endfunction

        function void absorb_item(opcode_t op, logic [LEN_W-1:0] len,
                                  logic [BYTE_W-1:0] din);
            logic [LEN_W-1:0]  room;
            status_t           st;
            ring_ptr_t         p;
            logic [BYTE_W-1:0] grabbed [$];
            room = LEN_W'(RING_BYTES) - fill;
            st = ST_REFUSE;
            case (op)
                OP_ENQ_START:
                begin
                    // A new start drops whatever transfer was still open.
                    pend = len;
                    pend_refused = (len > room);
                    st = pend_refused ? ST_REFUSE : ST_ACCEPT;
                end
                OP_ENQ_DATA:
                begin
                    if (pend != 0)
                    begin
                        pend--;
                        if (!pend_refused && fill < RING_BYTES)
                        begin
                            store[wr_ptr] = din;
                            written[wr_ptr] = 1'b1;
                            wr_ptr++;
                            fill++;
                            st = ST_ACCEPT;
                        end
                    end
                end
                OP_DEQUEUE, OP_PEEK:
                begin
                    if (len <= MAX_TRANSFER_DEF && fill != 0 && len <= fill)
                    begin
                        if (len == 0)
                            st = ST_ACCEPT;
                        else
                        begin
                            p = rd_ptr;
                            for (int unsigned i = 0; i < len; i++)
                            begin
                                grabbed.push_back(store[p]);
                                p++;
                            end
                            if (op == OP_DEQUEUE)
                            begin
                                rd_ptr = p;
                                fill -= len;
                            end
                            for (int unsigned i = 0; i < len; i++)
                                awaited_results.push_back(
                                    snapshot(ST_DATA, grabbed[i], i + 1 == len));
                            return;
                        end
                    end
                end
                OP_ADV_READ:
                begin
                    if (len <= fill)
                    begin
                        rd_ptr += ring_ptr_t'(len);
                        fill -= len;
                        st = ST_ACCEPT;
                    end
                end
                OP_ADV_WRITE:
                begin
                    if (len <= room)
                    begin
                        wr_ptr += ring_ptr_t'(len);
                        fill += len;
                        st = ST_ACCEPT;
                    end
                end
                OP_CLEAR:
                begin
                    rd_ptr = '0;
                    wr_ptr = '0;
                    fill = '0;
                    pend = '0;
                    pend_refused = 1'b0;
                    st = ST_ACCEPT;
                end
                default:
                    st = ST_REFUSE;
            endcase
            awaited_results.push_back(snapshot(st, '0, 1'b1));
        endfunction

        function void note_error(string msg);
            if (mismatches < 10)
                $display("mismatch at result beat %0d: %s", beats_checked, msg);
            mismatches++;
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want)
                note_error($sformatf("%s expected %0d, got %0d", name, want, got));
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (awaited_results.size() == 0)
                note_error("result beat with nothing awaited");
            else
            begin
                want = awaited_results.pop_front();
                compare_field("status", want.status, got.status);
                compare_field("data_byte_out", want.data, got.data);
                compare_field("last", want.last, got.last);
                compare_field("bytes_used", want.used, got.used);
                compare_field("bytes_free", want.free, got.free);
                compare_field("write_span", want.wspan, got.wspan);
                compare_field("read_span", want.rspan, got.rspan);
            end
            beats_checked++;
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n;
    logic                push;
    logic                full;
    logic [OP_W-1:0]     opcode;
    logic [LEN_W-1:0]    transfer_length;
    logic [BYTE_W-1:0]   data_byte_in;
    logic                empty;
    logic                pop;
    logic [STATUS_W-1:0] status;
    logic [BYTE_W-1:0]   data_byte_out;
    logic                last;
    logic [LEN_W-1:0]    bytes_used;
    logic [LEN_W-1:0]    bytes_free;
    logic [LEN_W-1:0]    write_span;
    logic [LEN_W-1:0]    read_span;

    byte_ring_shadow ring = new();

    int unsigned items_sent = 0;
    int unsigned send_idle_pct = 0;
    int unsigned pop_stall_pct = 0;
    bit          hold_off_req = 1'b0;

    int unsigned idle_plan [4] = '{0, 49, 0, 31};
    int unsigned stall_plan [4] = '{0, 0, 49, 31};

    circular_byte_buffer i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .opcode          (opcode),
        .transfer_length (transfer_length),
        .data_byte_in    (data_byte_in),
        .empty           (empty),
        .pop             (pop),
        .status          (status),
        .data_byte_out   (data_byte_out),
        .last            (last),
        .bytes_used      (bytes_used),
        .bytes_free      (bytes_free),
        .write_span      (write_span),
        .read_span       (read_span)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Feed every accepted input beat to the shadow. Sampling right at the
    // rising edge sees the values from before the edge.
    always @(posedge clk)
    begin
        if (rst_n && push && !full)
            ring.absorb_item(opcode_t'(opcode), transfer_length, data_byte_in);
    end

    // Check every result beat that leaves the block.
    always @(posedge clk)
    begin
        result_t beat;
        if (rst_n && pop && !empty)
        begin
            beat.status = status;
            beat.data = data_byte_out;
            beat.last = last;
            beat.used = bytes_used;
            beat.free = bytes_free;
            beat.wspan = write_span;
            beat.rspan = read_span;
            ring.check_result(beat);
        end
    end

    // Receiver: stall at random per phase; on request, hold pop low for a long
    // stretch so the block backs up and raises full.
    initial
    begin : receiver
        pop = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                pop = 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
            end
            pop = rst_n && ($urandom_range(99) >= pop_stall_pct);
        end
    end

    initial
    begin : watchdog
        #5_000_000;
        $display("[circular_byte_buffer] ERROR");
        $finish;
    end

    function automatic int unsigned min_u(int unsigned a, int unsigned b);
        return (a < b) ? a : b;
    endfunction

    // Offer one beat at the falling edge, hold it until accepted, and return
    // at the next falling edge. Idle gaps come first, at the sender's rate.
    task automatic offer_item(opcode_t op, int unsigned len, logic [BYTE_W-1:0] din);
        while ($urandom_range(99) < send_idle_pct)
        begin
            push = 1'b0;
            @(negedge clk);
        end
        push = 1'b1;
        opcode = op;
        transfer_length = len[LEN_W-1:0];
        data_byte_in = din;
        @(posedge clk);
        while (full)
            @(posedge clk);
        items_sent++;
        @(negedge clk);
    endtask

    // Stop sending until every owed result is back, then let the pipe settle.
    task automatic wait_for_drain();
        push = 1'b0;
        while (ring.awaited_results.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    // Dequeue or peek: mostly lengths that fit, some that are too long. Never
    // read bytes that were only skipped over by advance write; drop them with
    // an advance read instead.
    task automatic read_out(opcode_t op);
        int unsigned limit;
        int unsigned len;
        limit = min_u(ring.fill, MAX_TRANSFER_DEF);
        if ($urandom_range(6) == 0)
            len = $urandom_range(limit + 70, limit + 1);
        else
            len = $urandom_range(limit);
        if (len <= limit && !ring.bytes_defined(len))
            op = OP_ADV_READ;
        offer_item(op, len, 8'($urandom));
    endtask

    task automatic random_scenario();
        int unsigned pick;
        int unsigned n;
        int unsigned k;
        int unsigned len;
        pick = $urandom_range(99);
        if (pick < 35)
        begin
            // Well-formed enqueue: start, then its data beats. Very long ones
            // are cut short and left for the next start to abandon.
            n = ($urandom_range(9) == 0) ? $urandom_range(RING_BYTES) : $urandom_range(16);
            offer_item(OP_ENQ_START, n, 8'($urandom));
            k = 0;
            while (k < n && k < 24)
            begin
                if ($urandom_range(19) == 0)
                    offer_item(OP_ADV_WRITE, $urandom_range(2), 8'($urandom));
                offer_item(OP_ENQ_DATA, $urandom_range(RING_BYTES), 8'($urandom));
                k++;
            end
        end
        else if (pick < 55)
            read_out(OP_DEQUEUE);
        else if (pick < 65)
            read_out(OP_PEEK);
        else if (pick < 75)
        begin
            len = ($urandom_range(7) == 0) ? $urandom_range(RING_BYTES)
                                           : $urandom_range(min_u(ring.fill + 2, RING_BYTES));
            offer_item(OP_ADV_READ, len, 8'($urandom));
        end
        else if (pick < 85)
        begin
            len = ($urandom_range(7) == 0) ? $urandom_range(RING_BYTES) : $urandom_range(48);
            offer_item(OP_ADV_WRITE, len, 8'($urandom));
        end
        else if (pick < 90)
            offer_item(OP_ENQ_DATA, $urandom_range(RING_BYTES), 8'($urandom));
        else if (pick < 95)
            offer_item(OP_CLEAR, $urandom_range(RING_BYTES), 8'($urandom));
        else
            offer_item(OP_INVALID, $urandom_range(RING_BYTES), 8'($urandom));
    endtask

    task automatic directed_items();
        // Refusals on an empty ring: unused opcode, zero-length dequeue,
        // stray data beat, over-long advance read.
        offer_item(OP_INVALID, RING_BYTES, 8'hFF);
        offer_item(OP_DEQUEUE, 0, 8'h00);
        offer_item(OP_ENQ_DATA, 0, 8'h5A);
        offer_item(OP_ADV_READ, 1, 8'h00);
        // Start for the whole capacity, abandoned by a short one.
        offer_item(OP_ENQ_START, RING_BYTES, 8'h00);
        offer_item(OP_ENQ_START, 3, 8'h00);
        offer_item(OP_ENQ_DATA, 0, 8'h00);
        offer_item(OP_ENQ_DATA, 0, 8'hFF);
        offer_item(OP_ENQ_DATA, 0, 8'hA5);
        offer_item(OP_PEEK, 3, 8'h00);
        offer_item(OP_DEQUEUE, 4, 8'h00);
        offer_item(OP_DEQUEUE, 2, 8'h00);
        // Fill up by skipping ahead; a full ring is not an empty one.
        offer_item(OP_ADV_WRITE, RING_BYTES - 1, 8'h00);
        offer_item(OP_DEQUEUE, MAX_TRANSFER_DEF + 1, 8'h00);
        offer_item(OP_ENQ_START, 1, 8'h00);
        offer_item(OP_ENQ_DATA, 0, 8'h11);
        offer_item(OP_PEEK, 1, 8'h00);
        offer_item(OP_CLEAR, 0, 8'h00);
        // Move both indices near the top, then run out of room in mid-transfer.
        offer_item(OP_ADV_WRITE, 4000, 8'h00);
        offer_item(OP_ADV_READ, 4000, 8'h00);
        offer_item(OP_ENQ_START, 3, 8'h00);
        offer_item(OP_ADV_WRITE, RING_BYTES - 2, 8'h00);
        offer_item(OP_ENQ_DATA, 0, 8'h3C);
        offer_item(OP_ENQ_DATA, 0, 8'hC3);
        offer_item(OP_ENQ_DATA, 0, 8'h77);
        // Skip the unwritten stretch and read back the two stored bytes.
        offer_item(OP_ADV_READ, RING_BYTES - 2, 8'h00);
        offer_item(OP_DEQUEUE, 2, 8'h00);
    endtask

    initial
    begin : stimulus
        int unsigned phase_end;
        rst_n = 1'b0;
        push = 1'b0;
        opcode = OP_ENQ_START;
        transfer_length = '0;
        data_byte_in = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        directed_items();
        wait_for_drain();

        // Random phases with different idle and stall rates.
        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct = idle_plan[ph];
            pop_stall_pct = stall_plan[ph];
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end)
                random_scenario();
            wait_for_drain();
        end

        // Back-pressure: receiver holds off while the sender keeps pushing.
        send_idle_pct = 0;
        pop_stall_pct = 0;
        hold_off_req = 1'b1;
        phase_end = items_sent + HOLD_OFF_ITEMS;
        while (items_sent < phase_end)
            random_scenario();
        wait_for_drain();
        repeat (16) @(posedge clk);

        if (ring.mismatches == 0 && ring.awaited_results.size() == 0)
            $display("[circular_byte_buffer] OK");
        else
            $display("[circular_byte_buffer] ERROR");
        $finish;
    end

endmodule
